>>> hw/rtl/dsllex_pkg.sv
// ----------------------------------------------------------------------------
// dsllex_pkg
// Types, codes, keyword table and helpers for the byte-stream lexer.
// ----------------------------------------------------------------------------
package dsllex_pkg;

    localparam int MAX_KEYWORD_LEN = 19;
    localparam int NUM_WORDS       = 37;
    localparam int KEYWORD_COUNT   = 35;
    localparam int QUEUE_DEPTH     = 8;
    localparam int MAX_RESULTS     = 3;

    localparam logic [7:0] ARROW_B0 = 8'hE2;
    localparam logic [7:0] ARROW_B1 = 8'h86;
    localparam logic [7:0] ARROW_B2 = 8'h92;
    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;

    localparam logic [4:0] SYM_GE    = 5'd5;
    localparam logic [4:0] SYM_LE    = 5'd6;
    localparam logic [4:0] SYM_EQ    = 5'd7;
    localparam logic [4:0] SYM_NE    = 5'd8;
    localparam logic [4:0] SYM_ARROW = 5'd11;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_IDENT, M_NUM, M_NUM_DOT,
        M_STRING, M_OP, M_ARROW1, M_ARROW2, M_BOM1, M_BOM2
    } t_mode;

    typedef enum logic [3:0] {
        K_IDENT, K_KEYWORD, K_BOOL, K_INT, K_DEC, K_STRING, K_SYMBOL, K_END, K_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE, E_UNKNOWN, E_STR_NL, E_ESC_END, E_NO_QUOTE, E_OPEN_CMT
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  id;
        logic [19:0] line;
        logic [15:0] col;
        logic [15:0] len;
        t_err        err;
        logic        last;
    } t_tok;

    localparam logic [MAX_KEYWORD_LEN*8-1:0] WORD_ROWS [NUM_WORDS] = '{
        "agente", "runtime", "objetivo", "inteligencia", "herramientas",
        "memoria", "permisos", "restricciones", {"depende", "_de"}, "flujo",
        {"flujo", "_dinamico"}, "si", "sino", "persistente", "compartida",
        {"solo", "_lectura"}, "escritura", {"requiere", "_aprobacion"}, "usar", "leer",
        "enviar", "coordinador", {"memoria", "_compartida"}, "periodicidad",
        {"tiempo", "_real"}, "adaptabilidad", {"politica", "_validacion"}, "recibir",
        "responder", "difundir", "conectar", "escuchar", "delega", "coordina",
        "supervisa", "true", "false"
    };

    localparam logic [4:0] WORD_LEN [NUM_WORDS] = '{
        5'd6, 5'd7, 5'd8, 5'd12, 5'd12, 5'd7, 5'd8, 5'd13, 5'd10, 5'd5,
        5'd14, 5'd2, 5'd4, 5'd11, 5'd10, 5'd12, 5'd9, 5'd19, 5'd4, 5'd4,
        5'd6, 5'd11, 5'd18, 5'd12, 5'd11, 5'd13, 5'd19, 5'd7, 5'd9, 5'd8,
        5'd8, 5'd8, 5'd6, 5'd8, 5'd9, 5'd4, 5'd5
    };

    // character at pos of word idx; caller guarantees pos < length
    function automatic logic [7:0] word_char(input int idx, input logic [4:0] pos);
        int sh;
        sh = (int'(WORD_LEN[idx]) - 1 - int'(pos)) * 8;
        return 8'(WORD_ROWS[idx] >> sh);
    endfunction

    function automatic logic [5:0] single_symbol(input logic [7:0] b, output logic ok);
        ok = 1'b1;
        unique case (b)
            "{": return 6'd0;
            "}": return 6'd1;
            "=": return 6'd2;
            ">": return 6'd3;
            "<": return 6'd4;
            "-": return 6'd9;
            "!": return 6'd10;
            ":": return 6'd12;
            ",": return 6'd13;
            "(": return 6'd14;
            ")": return 6'd15;
            "[": return 6'd16;
            "]": return 6'd17;
            ";": return 6'd18;
            default: begin
                ok = 1'b0;
                return 6'd0;
            end
        endcase
    endfunction

endpackage

>>> hw/rtl/dsllex_if.sv
// ----------------------------------------------------------------------------
// dsllex_in_if / dsllex_out_if
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface dsllex_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] byte_value;
    modport source (output valid, cmd, byte_value, input ready);
    modport sink   (input valid, cmd, byte_value, output ready);
endinterface

interface dsllex_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [5:0]  symbol_id;
    logic [19:0] start_line;
    logic [15:0] start_column;
    logic [15:0] lexeme_length;
    logic [2:0]  error_code;
    logic        last;
    modport source (output valid, token_kind, symbol_id, start_line, start_column,
                    lexeme_length, error_code, last, input ready);
    modport sink   (input valid, token_kind, symbol_id, start_line, start_column,
                    lexeme_length, error_code, last, output ready);
endinterface

>>> hw/rtl/dsllex_front.sv
// ----------------------------------------------------------------------------
// dsllex_front
// One beat per cycle while the queue has space; runs the lexer state and pushes up to three tokens.
// ----------------------------------------------------------------------------
module dsllex_front
    import dsllex_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    dsllex_in_if.sink          i_in,
    input  logic               i_space_ok,
    output logic [1:0]         o_push_cnt,
    output t_tok               o_push [MAX_RESULTS]
);

    t_mode                 r_mode, n_mode;
    logic [19:0]           r_line, n_line, r_tline, n_tline;
    logic [15:0]           r_col, n_col, r_tcol, n_tcol;
    logic [15:0]           r_run, n_run;
    logic [7:0]            r_held, n_held;
    logic [NUM_WORDS-1:0]  r_cand, n_cand;
    logic                  r_dec, n_dec, r_esc, n_esc, r_halt, n_halt, r_mark, n_mark;

    logic acc;
    assign acc = i_in.valid && i_in.ready;
    assign i_in.ready = i_space_ok;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, n};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [NUM_WORDS-1:0] filt(input logic [NUM_WORDS-1:0] c,
                                                  input logic [15:0] p,
                                                  input logic [7:0] b);
        logic [NUM_WORDS-1:0] r;
        r = c;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (!(p < 16'(WORD_LEN[i]) && word_char(i, p[4:0]) == b)) r[i] = 1'b0;
        end
        return r;
    endfunction

    function automatic t_tok mk(input t_kind k, input logic [5:0] id, input logic [19:0] ln,
                                input logic [15:0] cl, input logic [15:0] len,
                                input t_err e);
        t_tok t;
        t.kind = k; t.id = id; t.line = ln; t.col = cl; t.len = len; t.err = e;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic t_tok word_tok(input logic [NUM_WORDS-1:0] c, input logic [15:0] run,
                                      input logic [19:0] ln, input logic [15:0] cl);
        t_tok t;
        t = mk(K_IDENT, 6'd0, ln, cl, run, E_NONE);
        if (run <= 16'(MAX_KEYWORD_LEN)) begin
            for (int i = NUM_WORDS - 1; i >= 0; i--) begin
                if (c[i] && run == 16'(WORD_LEN[i]))
                    t = mk((i < KEYWORD_COUNT) ? K_KEYWORD : K_BOOL, 6'(i), ln, cl, run,
                           E_NONE);
            end
        end
        return t;
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic        adv, do_idle, ok, is_dig, is_alp, is_sp, matched;
        logic [5:0]  k;
        logic [4:0]  opid;
        logic [16:0] dc;
        b = i_in.byte_value;
        n_mode = r_mode; n_line = r_line; n_col = r_col; n_tline = r_tline;
        n_tcol = r_tcol; n_run = r_run; n_held = r_held; n_cand = r_cand;
        n_dec = r_dec; n_esc = r_esc; n_halt = r_halt; n_mark = r_mark;
        o_push_cnt = 2'd0;
        for (int j = 0; j < MAX_RESULTS; j++) o_push[j] = mk(K_IDENT, 6'd0, 20'd0, 16'd0,
                                                            16'd0, E_NONE);
        adv = 1'b0; do_idle = 1'b0; matched = 1'b0; opid = 5'd0;
        is_dig = b >= "0" && b <= "9";
        is_alp = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        is_sp  = b == " " || (b >= 8'd9 && b <= 8'd13);
        k = single_symbol(b, ok);
        dc = {1'b0, r_tcol} + {1'b0, r_run};
        if (acc && i_in.cmd) begin
            if (!r_halt) begin
                unique case (r_mode)
                    M_BOM1, M_BOM2, M_SLASH, M_ARROW1, M_ARROW2: begin
                        o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_tline, r_tcol, 16'd1,
                                                E_UNKNOWN);
                        o_push_cnt++;
                    end
                    M_BLOCK, M_BSTAR: begin
                        o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_tline, r_tcol, 16'd2,
                                                E_OPEN_CMT);
                        o_push_cnt++;
                    end
                    M_IDENT: begin
                        o_push[o_push_cnt] = word_tok(r_cand, r_run, r_tline, r_tcol);
                        o_push_cnt++;
                    end
                    M_NUM, M_NUM_DOT: begin
                        o_push[o_push_cnt] = mk(r_dec ? K_DEC : K_INT, 6'd0, r_tline, r_tcol,
                                                r_run, E_NONE);
                        o_push_cnt++;
                        if (r_mode == M_NUM_DOT) begin
                            o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_tline,
                                                    dc[16] ? 16'hFFFF : dc[15:0], 16'd1,
                                                    E_UNKNOWN);
                            o_push_cnt++;
                        end
                    end
                    M_STRING: begin
                        o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_tline, r_tcol, r_run - 16'd1,
                                                r_esc ? E_ESC_END : E_NO_QUOTE);
                        o_push_cnt++;
                    end
                    M_OP: begin
                        k = single_symbol(r_held, ok);
                        o_push[o_push_cnt] = mk(K_SYMBOL, 6'(NUM_WORDS) + k, r_tline, r_tcol,
                                                16'd1, E_NONE);
                        o_push_cnt++;
                    end
                    default: ;
                endcase
            end
            o_push[o_push_cnt] = mk(K_END, 6'd0, r_line, r_col, 16'd0, E_NONE);
            o_push_cnt++;
            n_mode = M_IDLE; n_line = 20'd1; n_col = 16'd1; n_tline = 20'd1;
            n_tcol = 16'd1; n_run = 16'd0; n_held = 8'd0; n_cand = '1;
            n_dec = 1'b0; n_esc = 1'b0; n_halt = 1'b0; n_mark = 1'b0;
        end else if (acc && !r_halt) begin
            adv = 1'b1;
            if (!r_mark && b == BOM_B0) begin
                n_mark = 1'b1; n_tline = r_line; n_tcol = r_col; n_mode = M_BOM1;
                adv = 1'b0;
            end else begin
                n_mark = 1'b1;
                unique case (r_mode)
                    M_BOM1, M_BOM2, M_ARROW1, M_ARROW2, M_SLASH: begin
                        if (r_mode == M_BOM1 && b == BOM_B1) begin
                            n_mode = M_BOM2; adv = 1'b0;
                        end else if (r_mode == M_BOM2 && b == BOM_B2) begin
                            n_mode = M_IDLE; adv = 1'b0;
                        end else if (r_mode == M_ARROW1 && b == ARROW_B1) begin
                            n_mode = M_ARROW2; adv = 1'b0;
                        end else if (r_mode == M_ARROW2 && b == ARROW_B2) begin
                            o_push[o_push_cnt] = mk(K_SYMBOL, 6'(NUM_WORDS) + 6'(SYM_ARROW),
                                                    r_tline, r_tcol, 16'd3, E_NONE);
                            o_push_cnt++;
                            n_mode = M_IDLE; adv = 1'b0;
                        end else if (r_mode == M_SLASH && b == "/") begin
                            n_mode = M_LINE;
                        end else if (r_mode == M_SLASH && b == "*") begin
                            n_mode = M_BLOCK;
                        end else begin
                            o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_tline, r_tcol, 16'd1,
                                                    E_UNKNOWN);
                            o_push_cnt++;
                            n_halt = 1'b1; n_mode = M_IDLE;
                        end
                    end
                    M_LINE: if (b == 8'h0A) n_mode = M_IDLE;
                    M_BLOCK: if (b == "*") n_mode = M_BSTAR;
                    M_BSTAR: begin
                        if (b == "/") n_mode = M_IDLE;
                        else if (b != "*") n_mode = M_BLOCK;
                    end
                    M_IDENT: begin
                        if (is_alp || is_dig || b == "_") begin
                            n_cand = filt(r_cand, r_run, b);
                            n_run = sat_add(r_run, 16'd1);
                        end else begin
                            o_push[o_push_cnt] = word_tok(r_cand, r_run, r_tline, r_tcol);
                            o_push_cnt++;
                            do_idle = 1'b1;
                        end
                    end
                    M_NUM: begin
                        if (is_dig) n_run = sat_add(r_run, 16'd1);
                        else if (b == "." && !r_dec) n_mode = M_NUM_DOT;
                        else begin
                            o_push[o_push_cnt] = mk(r_dec ? K_DEC : K_INT, 6'd0, r_tline,
                                                    r_tcol, r_run, E_NONE);
                            o_push_cnt++;
                            do_idle = 1'b1;
                        end
                    end
                    M_NUM_DOT: begin
                        if (is_dig) begin
                            n_dec = 1'b1; n_run = sat_add(r_run, 16'd2); n_mode = M_NUM;
                        end else begin
                            o_push[o_push_cnt] = mk(r_dec ? K_DEC : K_INT, 6'd0, r_tline,
                                                    r_tcol, r_run, E_NONE);
                            o_push_cnt++;
                            o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_tline,
                                                    dc[16] ? 16'hFFFF : dc[15:0], 16'd1,
                                                    E_UNKNOWN);
                            o_push_cnt++;
                            n_halt = 1'b1; n_mode = M_IDLE;
                        end
                    end
                    M_STRING: begin
                        if (r_esc) begin
                            n_esc = 1'b0; n_run = sat_add(r_run, 16'd1);
                        end else if (b == "\"") begin
                            n_run = sat_add(r_run, 16'd1);
                            o_push[o_push_cnt] = mk(K_STRING, 6'd0, r_tline, r_tcol,
                                                    sat_add(r_run, 16'd1), E_NONE);
                            o_push_cnt++;
                            n_mode = M_IDLE;
                        end else if (b == 8'h0A || b == 8'h0D) begin
                            o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_tline, r_tcol,
                                                    r_run - 16'd1, E_STR_NL);
                            o_push_cnt++;
                            n_halt = 1'b1; n_mode = M_IDLE;
                        end else begin
                            if (b == "\\") n_esc = 1'b1;
                            n_run = sat_add(r_run, 16'd1);
                        end
                    end
                    M_OP: begin
                        if (b == ">" && r_held == "-") begin
                            matched = 1'b1; opid = SYM_ARROW;
                        end else if (b == "=" && r_held == ">") begin
                            matched = 1'b1; opid = SYM_GE;
                        end else if (b == "=" && r_held == "<") begin
                            matched = 1'b1; opid = SYM_LE;
                        end else if (b == "=" && r_held == "=") begin
                            matched = 1'b1; opid = SYM_EQ;
                        end else if (b == "=" && r_held == "!") begin
                            matched = 1'b1; opid = SYM_NE;
                        end
                        if (matched) begin
                            o_push[o_push_cnt] = mk(K_SYMBOL, 6'(NUM_WORDS) + 6'(opid),
                                                    r_tline, r_tcol, 16'd2, E_NONE);
                            o_push_cnt++;
                            n_mode = M_IDLE;
                        end else begin
                            o_push[o_push_cnt] = mk(K_SYMBOL,
                                                    6'(NUM_WORDS) + single_symbol(r_held, ok),
                                                    r_tline, r_tcol, 16'd1, E_NONE);
                            o_push_cnt++;
                            do_idle = 1'b1;
                        end
                    end
                    default: do_idle = 1'b1;
                endcase
                if (do_idle) begin
                    n_mode = M_IDLE;
                    k = single_symbol(b, ok);
                    if (is_sp) begin
                        n_mode = M_IDLE;
                    end else if (b == "/") begin
                        n_tline = r_line; n_tcol = r_col; n_mode = M_SLASH;
                    end else if (b == "\"") begin
                        n_tline = r_line; n_tcol = r_col; n_run = 16'd1; n_esc = 1'b0;
                        n_mode = M_STRING;
                    end else if (is_dig) begin
                        n_tline = r_line; n_tcol = r_col; n_run = 16'd1; n_dec = 1'b0;
                        n_mode = M_NUM;
                    end else if (is_alp || b == "_") begin
                        n_tline = r_line; n_tcol = r_col; n_run = 16'd1;
                        n_cand = filt('1, 16'd0, b); n_mode = M_IDENT;
                    end else if (b == "-" || b == ">" || b == "<" || b == "=" || b == "!") begin
                        n_tline = r_line; n_tcol = r_col; n_held = b; n_mode = M_OP;
                    end else if (b == ARROW_B0) begin
                        n_tline = r_line; n_tcol = r_col; n_mode = M_ARROW1;
                    end else if (ok) begin
                        o_push[o_push_cnt] = mk(K_SYMBOL, 6'(NUM_WORDS) + k, r_line, r_col,
                                                16'd1, E_NONE);
                        o_push_cnt++;
                    end else begin
                        o_push[o_push_cnt] = mk(K_ERROR, 6'd0, r_line, r_col, 16'd1,
                                                E_UNKNOWN);
                        o_push_cnt++;
                        n_halt = 1'b1;
                    end
                end
            end
            if (adv) begin
                if (b == 8'h0A) begin
                    n_line = (r_line != '1) ? r_line + 20'd1 : r_line;
                    n_col = 16'd1;
                end else begin
                    n_col = (r_col != '1) ? r_col + 16'd1 : r_col;
                end
            end
        end
        if (o_push_cnt != 2'd0) o_push[o_push_cnt - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= 20'd1; r_col <= 16'd1; r_tline <= 20'd1;
            r_tcol <= 16'd1; r_run <= 16'd0; r_held <= 8'd0; r_cand <= '1;
            r_dec <= 1'b0; r_esc <= 1'b0; r_halt <= 1'b0; r_mark <= 1'b0;
        end else begin
            r_mode <= n_mode; r_line <= n_line; r_col <= n_col; r_tline <= n_tline;
            r_tcol <= n_tcol; r_run <= n_run; r_held <= n_held; r_cand <= n_cand;
            r_dec <= n_dec; r_esc <= n_esc; r_halt <= n_halt; r_mark <= n_mark;
        end
    end

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_in.cmd && r_halt) |-> (o_push_cnt == 2'd0))
        else $error("tokens pushed while halted");

endmodule

>>> hw/rtl/dsllex_queue.sv
// ----------------------------------------------------------------------------
// dsllex_queue
// Token queue: up to three pushes per cycle, one beat out per cycle while ready is high.
// ----------------------------------------------------------------------------
module dsllex_queue
    import dsllex_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_cnt,
    input  t_tok          i_push [MAX_RESULTS],
    output logic          o_space_ok,
    dsllex_out_if.source  o_out
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_tok              r_mem [QUEUE_DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              pop;
    t_tok              head;

    assign o_space_ok = r_cnt <= (AW+1)'(QUEUE_DEPTH - MAX_RESULTS);
    assign pop = o_out.valid && o_out.ready;
    assign head = r_mem[r_rp];

    assign o_out.valid         = r_cnt != '0;
    assign o_out.token_kind    = head.kind;
    assign o_out.symbol_id     = head.id;
    assign o_out.start_line    = head.line;
    assign o_out.start_column  = head.col;
    assign o_out.lexeme_length = head.len;
    assign o_out.error_code    = head.err;
    assign o_out.last          = head.last;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < i_push_cnt) r_mem[r_wp + AW'(k)] <= i_push[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= r_wp + AW'(i_push_cnt);
            if (pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push_cnt) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QUEUE_DEPTH))
        else $error("token queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_cnt == $past(r_cnt) + (AW+1)'($past(i_push_cnt))
                                    - (AW+1)'($past(pop)))
        else $error("token queue count mismatch");

endmodule

>>> hw/rtl/dsl_byte_stream_lexer.sv
// ----------------------------------------------------------------------------
// dsl_byte_stream_lexer
// Streaming lexer for the agent-description language.
// ----------------------------------------------------------------------------
// One source byte (or end-of-input mark) is taken per cycle; the lexer state,
// counters and all 37 keyword compares update in that single cycle. Tokens
// (up to three per beat) go into an 8-entry queue that drives the output, so
// the input keeps flowing while tokens wait; input ready drops only when the
// queue has fewer than three free entries. An error stops token output until
// the end-of-input beat.
// ----------------------------------------------------------------------------
module dsl_byte_stream_lexer
    import dsllex_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dsllex_in_if.sink     i_in,
    dsllex_out_if.source  o_out
);

    logic [1:0] push_cnt;
    t_tok       push [MAX_RESULTS];
    logic       space_ok;

    dsllex_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_space_ok (space_ok),
        .o_push_cnt (push_cnt),
        .o_push     (push)
    );

    dsllex_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_out      (o_out)
    );

endmodule

>>> dv/tb_dsl_byte_stream_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dsl_byte_stream_lexer
// Drives source-byte beats into the lexer and checks every token beat against
// a token predictor kept in the testbench. Directed tests and one long output
// stall are followed by random well-formed programs with noise, all under
// random input gaps.
// ----------------------------------------------------------------------------
module tb_dsl_byte_stream_lexer;
    import dsllex_pkg::*;

    localparam int LINE_MAX = 1048575;
    localparam int COL_MAX  = 65535;

    logic i_clk;
    logic i_rst_n;
    int   n_errors;
    bit   hold_off;

    dsllex_in_if  in_ch ();
    dsllex_out_if out_ch ();

    dsl_byte_stream_lexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    string words [NUM_WORDS] = '{
        "agente", "runtime", "objetivo", "inteligencia", "herramientas",
        "memoria", "permisos", "restricciones", {"depende", "_de"}, "flujo",
        {"flujo", "_dinamico"}, "si", "sino", "persistente", "compartida",
        {"solo", "_lectura"}, "escritura", {"requiere", "_aprobacion"}, "usar", "leer",
        "enviar", "coordinador", {"memoria", "_compartida"}, "periodicidad",
        {"tiempo", "_real"}, "adaptabilidad", {"politica", "_validacion"}, "recibir",
        "responder", "difundir", "conectar", "escuchar", "delega", "coordina",
        "supervisa", "true", "false"
    };

    // lexer model state
    t_mode       lx_mode;
    int unsigned lx_line, lx_col, lx_tline, lx_tcol, lx_run;
    logic [7:0]  lx_held;
    string       lx_text;
    bit          lx_dec, lx_esc, lx_halted, lx_bom_seen;
    t_tok        token_q[$];

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic int sym_index(logic [7:0] b);
        case (b)
            "{": return 0;  "}": return 1;  "=": return 2;  ">": return 3;
            "<": return 4;  "-": return 9;  "!": return 10; ":": return 12;
            ",": return 13; "(": return 14; ")": return 15; "[": return 16;
            "]": return 17; ";": return 18;
            default: return -1;
        endcase
    endfunction

    function automatic void lx_reset();
        lx_mode = M_IDLE;
        lx_line = 1; lx_col = 1; lx_tline = 1; lx_tcol = 1;
        lx_run = 0; lx_held = 0; lx_text = "";
        lx_dec = 0; lx_esc = 0; lx_halted = 0; lx_bom_seen = 0;
    endfunction

    function automatic void push_tok(t_kind k, int id, int unsigned ln, int unsigned cl,
                                     int unsigned len, t_err e);
        t_tok t;
        t.kind = k; t.id = 6'(id); t.line = 20'(ln); t.col = 16'(cl);
        t.len = 16'(len); t.err = e; t.last = 1'b0;
        token_q.insert(token_q.size(), t);
    endfunction

    function automatic void lx_fail(t_err e, int unsigned ln, int unsigned cl,
                                    int unsigned len);
        push_tok(K_ERROR, 0, ln, cl, len, e);
        lx_halted = 1;
        lx_mode = M_IDLE;
    endfunction

    function automatic void run_add(int unsigned n);
        lx_run = (lx_run + n > COL_MAX) ? COL_MAX : lx_run + n;
    endfunction

    function automatic void mark_start();
        lx_tline = lx_line;
        lx_tcol = lx_col;
    endfunction

    function automatic void flush_word();
        for (int i = 0; i < NUM_WORDS; i++)
            if (lx_run == words[i].len() && lx_text == words[i]) begin
                push_tok(i < KEYWORD_COUNT ? K_KEYWORD : K_BOOL, i, lx_tline, lx_tcol,
                         lx_run, E_NONE);
                return;
            end
        push_tok(K_IDENT, 0, lx_tline, lx_tcol, lx_run, E_NONE);
    endfunction

    function automatic void flush_num();
        push_tok(lx_dec ? K_DEC : K_INT, 0, lx_tline, lx_tcol, lx_run, E_NONE);
    endfunction

    function automatic void dot_fail();
        int unsigned c;
        c = lx_tcol + lx_run;
        lx_fail(E_UNKNOWN, lx_tline, c > COL_MAX ? COL_MAX : c, 1);
    endfunction

    function automatic void flush_op();
        int k;
        k = sym_index(lx_held);
        push_tok(K_SYMBOL, NUM_WORDS + (k < 0 ? 0 : k), lx_tline, lx_tcol, 1, E_NONE);
    endfunction

    function automatic void idle_byte(logic [7:0] b);
        int k;
        lx_mode = M_IDLE;
        if (b == " " || (b >= 9 && b <= 13)) return;
        if (b == "/") begin mark_start(); lx_mode = M_SLASH; return; end
        if (b == "\"") begin
            mark_start(); lx_run = 1; lx_esc = 0; lx_mode = M_STRING; return;
        end
        if (is_dig(b)) begin
            mark_start(); lx_run = 1; lx_dec = 0; lx_mode = M_NUM; return;
        end
        if (is_alp(b) || b == "_") begin
            mark_start(); lx_run = 1; lx_text = string'(b); lx_mode = M_IDENT; return;
        end
        if (b == "-" || b == ">" || b == "<" || b == "=" || b == "!") begin
            mark_start(); lx_held = b; lx_mode = M_OP; return;
        end
        if (b == ARROW_B0) begin mark_start(); lx_mode = M_ARROW1; return; end
        k = sym_index(b);
        if (k >= 0) push_tok(K_SYMBOL, NUM_WORDS + k, lx_line, lx_col, 1, E_NONE);
        else lx_fail(E_UNKNOWN, lx_line, lx_col, 1);
    endfunction

    // returns 1 when the byte advances the counters
    function automatic bit lex_byte(logic [7:0] b);
        int id;
        if (!lx_bom_seen) begin
            lx_bom_seen = 1;
            if (b == BOM_B0) begin mark_start(); lx_mode = M_BOM1; return 0; end
        end
        case (lx_mode)
            M_BOM1: begin
                if (b == BOM_B1) begin lx_mode = M_BOM2; return 0; end
                lx_fail(E_UNKNOWN, lx_tline, lx_tcol, 1);
            end
            M_BOM2: begin
                if (b == BOM_B2) begin lx_mode = M_IDLE; return 0; end
                lx_fail(E_UNKNOWN, lx_tline, lx_tcol, 1);
            end
            M_SLASH: begin
                if (b == "/") lx_mode = M_LINE;
                else if (b == "*") lx_mode = M_BLOCK;
                else lx_fail(E_UNKNOWN, lx_tline, lx_tcol, 1);
            end
            M_LINE: if (b == 8'h0A) lx_mode = M_IDLE;
            M_BLOCK: if (b == "*") lx_mode = M_BSTAR;
            M_BSTAR: begin
                if (b == "/") lx_mode = M_IDLE;
                else if (b != "*") lx_mode = M_BLOCK;
            end
            M_IDENT: begin
                if (is_alp(b) || is_dig(b) || b == "_") begin
                    if (lx_text.len() <= MAX_KEYWORD_LEN) lx_text = {lx_text, string'(b)};
                    run_add(1);
                end else begin
                    flush_word(); idle_byte(b);
                end
            end
            M_NUM: begin
                if (is_dig(b)) run_add(1);
                else if (b == "." && !lx_dec) lx_mode = M_NUM_DOT;
                else begin flush_num(); idle_byte(b); end
            end
            M_NUM_DOT: begin
                if (is_dig(b)) begin lx_dec = 1; run_add(2); lx_mode = M_NUM; end
                else begin flush_num(); dot_fail(); end
            end
            M_STRING: begin
                if (lx_esc) begin lx_esc = 0; run_add(1); end
                else if (b == "\"") begin
                    run_add(1);
                    push_tok(K_STRING, 0, lx_tline, lx_tcol, lx_run, E_NONE);
                    lx_mode = M_IDLE;
                end else if (b == 8'h0A || b == 8'h0D) begin
                    lx_fail(E_STR_NL, lx_tline, lx_tcol, lx_run - 1);
                end else begin
                    if (b == "\\") lx_esc = 1;
                    run_add(1);
                end
            end
            M_OP: begin
                id = -1;
                if (lx_held == "-" && b == ">") id = SYM_ARROW;
                else if (lx_held == ">" && b == "=") id = SYM_GE;
                else if (lx_held == "<" && b == "=") id = SYM_LE;
                else if (lx_held == "=" && b == "=") id = SYM_EQ;
                else if (lx_held == "!" && b == "=") id = SYM_NE;
                if (id >= 0) begin
                    push_tok(K_SYMBOL, NUM_WORDS + id, lx_tline, lx_tcol, 2, E_NONE);
                    lx_mode = M_IDLE;
                end else begin
                    flush_op(); idle_byte(b);
                end
            end
            M_ARROW1: begin
                if (b == ARROW_B1) begin lx_mode = M_ARROW2; return 0; end
                lx_fail(E_UNKNOWN, lx_tline, lx_tcol, 1);
            end
            M_ARROW2: begin
                if (b == ARROW_B2) begin
                    push_tok(K_SYMBOL, NUM_WORDS + SYM_ARROW, lx_tline, lx_tcol, 3, E_NONE);
                    lx_mode = M_IDLE;
                    return 0;
                end
                lx_fail(E_UNKNOWN, lx_tline, lx_tcol, 1);
            end
            default: idle_byte(b);
        endcase
        return 1;
    endfunction

    function automatic void lex_end();
        if (!lx_halted) begin
            case (lx_mode)
                M_BOM1, M_BOM2, M_SLASH, M_ARROW1, M_ARROW2:
                    lx_fail(E_UNKNOWN, lx_tline, lx_tcol, 1);
                M_BLOCK, M_BSTAR: lx_fail(E_OPEN_CMT, lx_tline, lx_tcol, 2);
                M_IDENT: flush_word();
                M_NUM: flush_num();
                M_NUM_DOT: begin flush_num(); dot_fail(); end
                M_STRING: lx_fail(lx_esc ? E_ESC_END : E_NO_QUOTE, lx_tline, lx_tcol,
                                  lx_run - 1);
                M_OP: flush_op();
                default: ;
            endcase
        end
        push_tok(K_END, 0, lx_line, lx_col, 0, E_NONE);
        lx_reset();
    endfunction

    function automatic void predict_beat(logic c, logic [7:0] b);
        int n0;
        n0 = token_q.size();
        if (c) lex_end();
        else if (!lx_halted && lex_byte(b)) begin
            if (b == 8'h0A) begin
                if (lx_line < LINE_MAX) lx_line++;
                lx_col = 1;
            end else if (lx_col < COL_MAX) lx_col++;
        end
        if (token_q.size() > n0) token_q[$].last = 1'b1;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 40) return 0;
        if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays up after a beat until the next call drops it or sends again
    task automatic send_beat(logic c, logic [7:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c;
        in_ch.byte_value <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_beat(c, b);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_beat(1'b0, s[i]);
    endtask

    task automatic send_end();
        send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // output side: random stalls, long hold-off when asked
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 99) < 8) out_ch.ready <= 1'b0;
            else out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_tok e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (token_q.size() == 0) begin
                $error("token beat with nothing expected");
                n_errors++;
            end else begin
                e = token_q.pop_front();
                if (out_ch.token_kind !== e.kind) begin
                    $error("token_kind exp %0d got %0d", e.kind, out_ch.token_kind);
                    n_errors++;
                end
                if (out_ch.symbol_id !== e.id) begin
                    $error("symbol_id exp %0d got %0d", e.id, out_ch.symbol_id);
                    n_errors++;
                end
                if (out_ch.start_line !== e.line) begin
                    $error("start_line exp %0d got %0d", e.line, out_ch.start_line);
                    n_errors++;
                end
                if (out_ch.start_column !== e.col) begin
                    $error("start_column exp %0d got %0d", e.col, out_ch.start_column);
                    n_errors++;
                end
                if (out_ch.lexeme_length !== e.len) begin
                    $error("lexeme_length exp %0d got %0d", e.len, out_ch.lexeme_length);
                    n_errors++;
                end
                if (out_ch.error_code !== e.err) begin
                    $error("error_code exp %0d got %0d", e.err, out_ch.error_code);
                    n_errors++;
                end
                if (out_ch.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, out_ch.last);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_keywords();
        send_text({8'hEF, 8'hBB, 8'hBF, "agente true false requiere", "_aprobacion x_1"});
        send_text(" 0 9.5 7. 3");
        send_end();
    endtask

    task automatic test_symbols();
        send_text({"{}=><>=<===!=-!->:,()[];", 8'hE2, 8'h86, 8'h92, "// c\n/* * */"});
        send_text("\"a\\\"b\" \t\n");
        send_end();
    endtask

    task automatic test_errors();
        send_text("1.x"); send_end();
        send_text("a / b"); send_end();
        send_text("\"ab\nz"); send_end();
        send_text("\"a\\"); send_end();
        send_text("/* x"); send_end();
        send_text({8'hE2, 8'h86}); send_end();
        send_text({8'hEF, 8'hBB, "a"}); send_end();
        send_text({8'hFF, 8'h00}); send_end();
    endtask

    function automatic string rand_piece();
        string s;
        int k;
        k = $urandom_range(0, 11);
        case (k)
            0, 1: s = words[$urandom_range(0, NUM_WORDS - 1)];
            2: s = {"id", string'(8'($urandom_range("a", "z"))), "_9"};
            3: s = $sformatf("%0d", $urandom_range(0, 99999));
            4: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 9));
            5: s = "\"txt \\n ok\"";
            6: s = (k == 6 && $urandom_range(0, 1)) ? "->" : ">=";
            7: s = {8'hE2, 8'h86, 8'h92};
            8: s = "// note\n";
            9: s = "/* blk ** */";
            10: s = string'(8'($urandom_range(0, 255)));
            default: s = "{}:,;()[]!=<=";
        endcase
        return s;
    endfunction

    task automatic test_random(int n_bytes);
        int sent;
        string p;
        sent = 0;
        while (sent < n_bytes) begin
            p = rand_piece();
            send_text(p);
            sent += p.len();
            send_text($urandom_range(0, 3) == 0 ? "\n" : " ");
            sent++;
            if ($urandom_range(0, 9) == 0) begin send_end(); sent++; end
        end
        send_end();
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                repeat (10) send_text("( ");
                send_end();
            end
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end
        join
    endtask

    initial begin
        n_errors = 0;
        hold_off = 0;
        lx_reset();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = 1'b0;
        in_ch.byte_value = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_keywords();
        test_symbols();
        test_errors();
        test_backpressure();
        test_random(20);
        in_ch.valid <= 1'b0;
        repeat (20000) begin
            if (token_q.size() == 0) break;
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && token_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/dsllex_pkg.sv
hw/rtl/dsllex_if.sv
hw/rtl/dsllex_front.sv
hw/rtl/dsllex_queue.sv
hw/rtl/dsl_byte_stream_lexer.sv
dv/tb_dsl_byte_stream_lexer.sv
